[rtl/far_pkg.sv]
// Shared types, constants and the answer length table of the framed answer receiver.
`default_nettype none

package far_pkg;

	localparam int MAX_FRAME_DEF = 4096;

	// result queue
	localparam int QDEPTH  = 8;
	localparam int QIDX_W  = $clog2(QDEPTH);
	localparam int QLVL_W  = $clog2(QDEPTH + 1);
	localparam int RES_MAX = 2;

	localparam int APB_AW = 3;

	localparam logic [15:0] START_PAIR = 16'hA0A2;

	localparam logic [7:0] ID_B5 = 8'hB5;
	localparam logic [7:0] ID_B7 = 8'hB7;
	localparam logic [7:0] ID_B8 = 8'hB8;
	localparam logic [7:0] ID_BA = 8'hBA;
	localparam logic [7:0] ID_BB = 8'hBB;
	localparam logic [7:0] ID_BC = 8'hBC;
	localparam logic [7:0] ID_BF = 8'hBF;
	localparam logic [7:0] ID_C0 = 8'hC0;

	localparam logic [15:0] SHORT_B7_LEN = 16'd20;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SUM   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN   = 2'd2;
	localparam logic [1:0] ST_TOO_LARGE = 2'd3;

	localparam logic REG_TRAIL  = 1'b0;
	localparam logic REG_ENDSEQ = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  answer_code;
		logic [11:0] param_count;
		logic [1:0]  status;
	} far_result_t;

	// results of one byte, in order; count is 0, 1 or 2
	typedef struct packed {
		logic [1:0]  count;
		far_result_t first;
		far_result_t second;
	} far_push_t;

	typedef struct packed {
		logic        known;
		logic [10:0] params;
		logic [1:0]  trail;
	} far_ans_t;

	function automatic far_ans_t far_lookup(input logic [7:0] id);
		far_ans_t r;
		r.known  = 1'b1;
		r.trail  = 2'd2;
		r.params = 11'd0;
		case (id)
			ID_B7: r.params = 11'd44;
			ID_B8: r.params = 11'd4;
			ID_BB: r.params = 11'd0;
			ID_B5: r.params = 11'd1024;
			ID_BA: r.params = 11'd4;
			ID_BF: r.params = 11'd8;
			ID_C0: r.params = 11'd4;
			ID_BC: r.trail  = 2'd0;
			default: begin
				r.known = 1'b0;
				r.trail = 2'd0;
			end
		endcase
		return r;
	endfunction

	function automatic far_result_t far_mk(input logic kind, input logic [7:0] data,
			input logic [7:0] code, input logic [11:0] count, input logic [1:0] status);
		far_result_t r;
		r.kind        = kind;
		r.data_byte   = data;
		r.answer_code = code;
		r.param_count = count;
		r.status      = status;
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/far_if.sv]
// Valid/ready channel interfaces for received bytes and for results.
`default_nettype none

interface far_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface far_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  answer_code;
	logic [11:0] param_count;
	logic [1:0]  status;

	modport source (output valid, output kind, output data_byte, output answer_code,
		output param_count, output status, input ready);
	modport sink (input valid, input kind, input data_byte, input answer_code,
		input param_count, input status, output ready);
endinterface

`default_nettype wire

[rtl/far_rx_core.sv]
// Frame parser: input byte register, frame state and result generation.
`default_nettype none

module far_rx_core #(
	parameter int MAX_FRAME = far_pkg::MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_take,
	input  wire logic [7:0]        in_byte,
	input  wire logic              trail_en,
	input  wire logic              endseq_en,
	output logic                   busy,
	output far_pkg::far_push_t     push
);
	import far_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME + 1);
	localparam int PE_W  = POS_W + 1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_HEAD = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef struct packed {
		logic        data_hit;
		logic        end_hit;
		logic [14:0] sum;
		logic [15:0] rsum;
	} fb_t;

	// one frame byte at position p, once the frame length is known
	function automatic fb_t frame_byte(input logic [POS_W-1:0] p, input logic [7:0] b,
			input logic [14:0] sum, input logic [15:0] rsum,
			input logic [POS_W-1:0] fl, input logic [POS_W-1:0] pl);
		fb_t r;
		logic [PE_W-1:0] pe;
		logic [PE_W-1:0] fe;
		pe = {1'b0, p};
		fe = {1'b0, fl};
		r.sum      = sum;
		r.rsum     = rsum;
		r.data_hit = pe < ({1'b0, pl} + PE_W'(5));
		if (pe + PE_W'(5) <= fe)
			r.sum = sum + {7'd0, b};
		if (pe + PE_W'(4) == fe)
			r.rsum = {b, 8'h00};
		if (pe + PE_W'(3) == fe)
			r.rsum = r.rsum | {8'h00, b};
		r.end_hit = (pe + PE_W'(1) == fe);
		return r;
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	phase_t           phase_q, phase_d;
	logic [15:0]      win_q, win_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] fl_q, fl_d;
	logic [POS_W-1:0] pl_q, pl_d;
	logic [15:0]      lf_q, lf_d;
	logic [7:0]       ans_q, ans_d;
	logic [14:0]      sum_q, sum_d;
	logic [15:0]      rsum_q, rsum_d;
	logic [7:0]       held_q, held_d;

	// header resolution, used when the second parameter byte arrives
	logic [7:0]       code_c;
	far_ans_t         lk;
	logic [19:0]      hdr_cnt;
	logic [19:0]      plen;
	logic [19:0]      flen;
	logic             too_big;
	logic [POS_W-1:0] pl_new;
	logic [POS_W-1:0] fl_new;
	logic [19:0]      pl_new_w;
	logic [19:0]      pl_q_w;
	logic [11:0]      big_cnt;
	fb_t              fb_a, fb_b, fb_body;
	logic [1:0]       end_st;

	assign code_c  = (ans_q == ID_B7 && lf_q <= SHORT_B7_LEN) ? ID_B8 : ans_q;
	assign lk      = far_lookup(code_c);
	assign hdr_cnt = {4'd0, held_q, byte_s1};
	assign plen    = ((code_c == ID_BB) ? ((hdr_cnt << 3) + (hdr_cnt << 2) + 20'd4)
	                                    : 20'(lk.params))
	               + (trail_en ? 20'(lk.trail) : 20'd0);
	assign flen    = plen + 20'd9 + (endseq_en ? 20'd2 : 20'd0);
	assign too_big = flen > 20'(MAX_FRAME);
	assign pl_new  = plen[POS_W-1:0];
	assign fl_new  = flen[POS_W-1:0];
	assign pl_new_w = 20'(pl_new);
	assign pl_q_w   = 20'(pl_q);
	assign big_cnt  = (plen > 20'd4095) ? 12'hFFF : plen[11:0];

	assign fb_a    = frame_byte(POS_W'(5), held_q, sum_q, rsum_q, fl_new, pl_new);
	assign fb_b    = frame_byte(POS_W'(6), byte_s1, fb_a.sum, fb_a.rsum, fl_new, pl_new);
	assign fb_body = frame_byte(pos_q, byte_s1, sum_q, rsum_q, fl_q, pl_q);
	assign end_st  = ({1'b0, fb_body.sum} != fb_body.rsum) ? ST_BAD_SUM : ST_OK;

	assign busy = valid_s1;

	always_comb begin
		phase_d = phase_q;
		win_d   = win_q;
		pos_d   = pos_q;
		fl_d    = fl_q;
		pl_d    = pl_q;
		lf_d    = lf_q;
		ans_d   = ans_q;
		sum_d   = sum_q;
		rsum_d  = rsum_q;
		held_d  = held_q;
		push    = '0;
		if (valid_s1) begin
			case (phase_q)
				PH_HEAD: begin
					pos_d = pos_q + POS_W'(1);
					if (pos_q == POS_W'(2)) begin
						lf_d = {byte_s1, 8'h00};
					end else if (pos_q == POS_W'(3)) begin
						lf_d = lf_q | {8'h00, byte_s1};
					end else if (pos_q == POS_W'(4)) begin
						ans_d = byte_s1;
						sum_d = {7'd0, byte_s1};
					end else if (pos_q == POS_W'(5)) begin
						held_d = byte_s1;
					end else begin
						ans_d = code_c;
						if (!lk.known) begin
							push.count = 2'd1;
							push.first = far_mk(KIND_END, 8'h00, code_c, 12'd0, ST_UNKNOWN);
							phase_d = PH_HUNT;
							win_d   = '0;
						end else if (too_big) begin
							push.count = 2'd1;
							push.first = far_mk(KIND_END, 8'h00, code_c, big_cnt, ST_TOO_LARGE);
							phase_d = PH_HUNT;
							win_d   = '0;
						end else begin
							// bytes 5 and 6 go through as ordinary frame bytes
							pl_d    = pl_new;
							fl_d    = fl_new;
							phase_d = PH_BODY;
							pos_d   = POS_W'(7);
							sum_d   = fb_b.sum;
							rsum_d  = fb_b.rsum;
							push.count = 2'(fb_a.data_hit) + 2'(fb_b.data_hit);
							push.first = far_mk(KIND_DATA, fb_a.data_hit ? held_q : byte_s1,
								code_c, pl_new_w[11:0], ST_OK);
							push.second = far_mk(KIND_DATA, byte_s1, code_c, pl_new_w[11:0], ST_OK);
						end
					end
				end
				PH_BODY: begin
					pos_d  = pos_q + POS_W'(1);
					sum_d  = fb_body.sum;
					rsum_d = fb_body.rsum;
					if (fb_body.data_hit) begin
						push.count = 2'd1;
						push.first = far_mk(KIND_DATA, byte_s1, ans_q, pl_q_w[11:0], ST_OK);
					end else if (fb_body.end_hit) begin
						push.count = 2'd1;
						push.first = far_mk(KIND_END, 8'h00, ans_q, pl_q_w[11:0], end_st);
					end
					if (fb_body.end_hit) begin
						phase_d = PH_HUNT;
						win_d   = '0;
					end
				end
				default: begin
					win_d = {win_q[7:0], byte_s1};
					if (win_d == START_PAIR) begin
						phase_d = PH_HEAD;
						pos_d   = POS_W'(2);
						lf_d    = '0;
						sum_d   = '0;
						rsum_d  = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_HUNT;
			win_q    <= '0;
			pos_q    <= '0;
			fl_q     <= '0;
			pl_q     <= '0;
			lf_q     <= '0;
			ans_q    <= '0;
			sum_q    <= '0;
			rsum_q   <= '0;
			held_q   <= '0;
		end else begin
			valid_s1 <= in_take;
			phase_q  <= phase_d;
			win_q    <= win_d;
			pos_q    <= pos_d;
			fl_q     <= fl_d;
			pl_q     <= pl_d;
			lf_q     <= lf_d;
			ans_q    <= ans_d;
			sum_q    <= sum_d;
			rsum_q   <= rsum_d;
			held_q   <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			byte_s1 <= in_byte;
	end

`ifndef SYNTH
	a_two_only_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> valid_s1 && phase_q == PH_HEAD)
		else $error("two results outside header completion");

	a_no_idle_results: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> valid_s1)
		else $error("result produced without a byte in stage 1");

	a_end_rehunts: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && phase_q == PH_BODY && fb_body.end_hit |=>
			phase_q == PH_HUNT && win_q == 16'h0000)
		else $error("frame end did not restart the hunt");
`endif

endmodule

`default_nettype wire

[rtl/far_out_q.sv]
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module far_out_q (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire far_pkg::far_push_t          push,
	input  wire logic                        pop,
	output far_pkg::far_result_t             head,
	output logic [far_pkg::QLVL_W-1:0]       level
);
	import far_pkg::*;

	far_result_t       mem_q [QDEPTH];
	logic [QIDX_W-1:0] head_q;
	logic [QIDX_W-1:0] tail_q;
	logic [QLVL_W-1:0] level_q;

	assign head  = mem_q[head_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[tail_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[tail_q + QIDX_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			tail_q  <= tail_q + QIDX_W'(push.count);
			head_q  <= head_q + QIDX_W'(pop);
			level_q <= level_q + QLVL_W'(push.count) - QLVL_W'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> level_q <= QLVL_W'(QDEPTH) - QLVL_W'(push.count))
		else $error("result queue overflow");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= QLVL_W'(QDEPTH))
		else $error("result queue level out of range");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> level_q == $past(level_q) - QLVL_W'(1))
		else $error("pop did not lower the level");
`endif

endmodule

`default_nettype wire

[rtl/framed_answer_receiver.sv]
// Path: each byte is registered in stage 1; its results go into the result queue, which offers them on res_out.
// Throughput: one byte per cycle; a byte yields at most two results (two only when the
//   header completes); ready drops while the 8-entry result queue holds more than 6
//   results, or more than 4 while a byte sits in stage 1.
// Reset: arst_n is asynchronous; it clears the parser to start-pair hunt, empties the
//   queue and sets both configuration registers to 1.
`default_nettype none

module framed_answer_receiver #(
	parameter int MAX_FRAME = far_pkg::MAX_FRAME_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	far_in_if.sink                           rx_in,
	far_out_if.source                        res_out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [far_pkg::APB_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import far_pkg::*;

	localparam logic [QLVL_W-1:0] LVL_IDLE = QLVL_W'(QDEPTH - RES_MAX);
	localparam logic [QLVL_W-1:0] LVL_BUSY = QLVL_W'(QDEPTH - 2 * RES_MAX);

	logic              trail_en_q;
	logic              endseq_en_q;
	logic              in_take;
	logic              busy;
	logic              pop;
	far_push_t         push;
	far_result_t       head;
	logic [QLVL_W-1:0] level;
	logic              cfg_wr;

	// room for this byte's results plus those of the byte in stage 1
	assign rx_in.ready = busy ? (level <= LVL_BUSY) : (level <= LVL_IDLE);
	assign in_take     = rx_in.valid && rx_in.ready;

	assign res_out.valid       = (level != '0);
	assign res_out.kind        = head.kind;
	assign res_out.data_byte   = head.data_byte;
	assign res_out.answer_code = head.answer_code;
	assign res_out.param_count = head.param_count;
	assign res_out.status      = head.status;
	assign pop                 = res_out.valid && res_out.ready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trail_en_q  <= 1'b1;
			endseq_en_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TRAIL:  trail_en_q  <= pwdata[0];
				REG_ENDSEQ: endseq_en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TRAIL:  prdata = {31'd0, trail_en_q};
			REG_ENDSEQ: prdata = {31'd0, endseq_en_q};
			default:    prdata = 32'd0;
		endcase
	end

	far_rx_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.in_byte   (rx_in.rx_byte),
		.trail_en  (trail_en_q),
		.endseq_en (endseq_en_q),
		.busy      (busy),
		.push      (push)
	);

	far_out_q u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

endmodule

`default_nettype wire
